// ===== hdl/lcbp_pkg.sv =====
// Shared types, Q3.12 arithmetic helpers and the tanh lookup table.
package lcbp_pkg;

  localparam int Q_FRAC = 12;
  localparam logic signed [16:0] ONE_Q12 = 17'sd4096;
  localparam int LUT_SIZE = 1024;
  localparam int LUT_AW = 10;

  typedef logic signed [15:0] q12_t;
  typedef logic signed [31:0] acc_t;
  typedef q12_t tanh_lut_t [LUT_SIZE];

  function automatic q12_t sat16(input logic signed [16:0] v);
    q12_t r;
    if (v > 17'sd32767) r = 16'sh7fff;
    else if (v < -17'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // product >>> 12 (floor), saturated
  function automatic q12_t qmul(input q12_t a, input q12_t b);
    logic signed [31:0] p;
    logic signed [31:0] q;
    p = a * b;
    q = p >>> Q_FRAC;
    if (q > 32'sd32767) return 16'sh7fff;
    else if (q < -32'sd32768) return 16'sh8000;
    else return q[15:0];
  endfunction

  function automatic q12_t one_minus(input q12_t y);
    return sat16(ONE_Q12 - 17'(y));
  endfunction

  function automatic acc_t sat_add32(input acc_t a, input q12_t d);
    logic signed [32:0] s;
    s = 33'(a) + 33'(d);
    if (s > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
    else if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

  // --- table build, elaboration only ---

  // e^(-1/64) in Q62, series to eleven terms, each term truncated
  localparam longint unsigned EXP_ONE = 64'd1 << 62;
  localparam longint unsigned EXP_T1  = EXP_ONE / 64'd64;
  localparam longint unsigned EXP_T2  = EXP_T1 / 64'd128;
  localparam longint unsigned EXP_T3  = EXP_T2 / 64'd192;
  localparam longint unsigned EXP_T4  = EXP_T3 / 64'd256;
  localparam longint unsigned EXP_T5  = EXP_T4 / 64'd320;
  localparam longint unsigned EXP_T6  = EXP_T5 / 64'd384;
  localparam longint unsigned EXP_T7  = EXP_T6 / 64'd448;
  localparam longint unsigned EXP_T8  = EXP_T7 / 64'd512;
  localparam longint unsigned EXP_T9  = EXP_T8 / 64'd576;
  localparam longint unsigned EXP_T10 = EXP_T9 / 64'd640;
  localparam longint unsigned EXP_BASE = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                         - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                         + EXP_T10;

  function automatic longint unsigned mul_q62(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al = a & 64'hffff_ffff; ah = a >> 32;
    bl = b & 64'hffff_ffff; bh = b >> 32;
    ll = al * bl; lh = al * bh; hl = ah * bl; hh = ah * bh;
    mid = (ll >> 32) + (lh & 64'hffff_ffff) + (hl & 64'hffff_ffff);
    lo = (ll & 64'hffff_ffff) | (mid << 32);
    hi = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // shift-subtract quotient, enough for results below 2^14
  function automatic longint unsigned udiv_small(input longint unsigned n,
                                                 input longint unsigned d);
    longint unsigned q, r;
    q = 64'd0;
    r = n;
    for (int b = 13; b >= 0; b--) begin
      if (r >= (d << b)) begin
        r = r - (d << b);
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic int tanh_point(input int unsigned m_in,
                                    input longint unsigned base);
    longint unsigned e, p, e40, num, den;
    int unsigned m;
    e = 64'd1 << 62;
    p = base;
    m = m_in;
    while (m != 0) begin
      if (m[0]) e = mul_q62(e, p);
      p = mul_q62(p, p);
      m = m >> 1;
    end
    e40 = (e + (64'd1 << 21)) >> 22;
    num = (64'd1 << 40) - e40;
    den = (64'd1 << 40) + e40;
    return int'(udiv_small(num * 64'd8192 + den, den * 64'd2));
  endfunction

  function automatic tanh_lut_t build_lut();
    tanh_lut_t t;
    for (int k = 0; k < LUT_SIZE; k++) begin
      if (k < 512) t[k] = 16'(-tanh_point(512 - k, EXP_BASE));
      else t[k] = 16'(tanh_point(k - 512, EXP_BASE));
    end
    return t;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_lut();

  function automatic q12_t tanh_q(input q12_t x);
    logic signed [16:0] s;
    logic [LUT_AW-1:0] idx;
    s = 17'(x) + 17'sd16384;
    if (x < -16'sd16384) idx = '0;
    else if (x > 16'sd16383) idx = '1;
    else idx = s[14:5];
    return TANH_LUT[idx];
  endfunction

endpackage

// ===== hdl/lstm_cell_backward_pointwise.sv =====
// LSTM backward pointwise stage with zoneout and a per-row bias gradient store.
//
//  channel | ports                               | width      | moves
//  --------+-------------------------------------+------------+---------------------------
//  in      | in_tvalid / in_tready / in_tdata    | 184 bits   | one element per transaction
//  out     | out_tvalid / out_tready / out_tdata | 224 bits   | one result per element
//  cfg     | cfg_valid / cfg_ready / cfg_data    | 1 bit      | zoneout_enable
//
// An element is accepted, then passes seven steps through the chain of
// dependent Q3.12 multiplies, the last of which does the read-modify-write
// of the bias row. The result sits in an output register; the next element
// is accepted while it waits, and the final step stalls only if the previous
// result is still untaken. Reset (synchronous, rst_n low) clears the
// per-row valid bits, so every bias sum reads as zero until first written.
module lstm_cell_backward_pointwise
  import lcbp_pkg::*;
#(
  parameter int HIDDEN = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row[7:0], cell_prev, cell_new, grad_h_new, grad_c_new, grad_h_carry,
  // grad_c_carry, gate_input, gate_cand, gate_forget, gate_output, keep_mask
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // grad_h_out, grad_c_out, grad_pre_i, grad_pre_g, grad_pre_f, grad_pre_o
  // (16 bits each), bias_sum_i, bias_sum_g, bias_sum_f, bias_sum_o (32 each)
  output logic [223:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data
);

  // row field is 8 bits, so at most 256 rows are reachable
  localparam int ROWS = (HIDDEN < 256) ? HIDDEN : 256;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ZO   = 3'd1;
  localparam logic [2:0] ST_A    = 3'd2;
  localparam logic [2:0] ST_B    = 3'd3;
  localparam logic [2:0] ST_C    = 3'd4;
  localparam logic [2:0] ST_D    = 3'd5;
  localparam logic [2:0] ST_E    = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // bias store: one row holds the four gate sums {o, f, g, i}
  logic [127:0] mem [ROWS];
  logic [ROWS-1:0] row_valid_r;

  logic [2:0] state_r;
  logic       zo_en_r;
  logic       out_valid_r;
  logic [223:0] out_data_r;

  logic [AW-1:0] addr_r;
  logic          in_range_r;
  logic          rd_valid_r;
  logic [127:0]  rd_data_r;

  q12_t cp_r, gi_r, gg_r, gf_r, go_r, mask_r, ct_r;
  q12_t dht_r, dct_r, dho_r;
  q12_t do_r, dcth_r, dtc_r, t_r;
  q12_t dsg_o_r, dsg_i_r, dsg_f_r, dtg_r;
  q12_t df_r, dc_r, di_r, dg_r;
  q12_t vo_r, vi_r, vg_r, vf_r;

  logic [7:0] in_row;
  logic       in_acc;
  logic       fin_go;
  logic [AW-1:0] in_addr;
  logic [127:0] old_row;
  acc_t si, sg, sf, so;

  assign in_row    = in_tdata[7:0];
  assign in_addr   = in_row[AW-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // unwritten rows read as zero
  assign old_row = rd_valid_r ? rd_data_r : '0;
  always_comb begin
    si = sat_add32(old_row[31:0],   vi_r);
    sg = sat_add32(old_row[63:32],  vg_r);
    sf = sat_add32(old_row[95:64],  vf_r);
    so = sat_add32(old_row[127:96], vo_r);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zo_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (cfg_valid) zo_en_r <= cfg_data[0];
      unique case (state_r)
        ST_IDLE: if (in_acc) state_r <= ST_ZO;
        ST_FIN:  if (fin_go) state_r <= ST_IDLE;
        default: state_r <= state_r + 3'd1;
      endcase
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (in_range_r) row_valid_r[addr_r] <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bias memory: read on accept, write back on the final step
  always_ff @(posedge clk) begin
    if (in_acc) rd_data_r <= mem[in_addr];
    if (fin_go && in_range_r) mem[addr_r] <= {so, sf, sg, si};
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r     <= in_addr;
      in_range_r <= (32'(in_row) < 32'(HIDDEN));
      rd_valid_r <= row_valid_r[in_addr];
      cp_r   <= in_tdata[23:8];
      ct_r   <= tanh_q(in_tdata[39:24]);
      dht_r  <= sat16(17'(signed'(in_tdata[55:40])) + 17'(signed'(in_tdata[87:72])));
      dct_r  <= sat16(17'(signed'(in_tdata[71:56])) + 17'(signed'(in_tdata[103:88])));
      gi_r   <= in_tdata[119:104];
      gg_r   <= in_tdata[135:120];
      gf_r   <= in_tdata[151:136];
      go_r   <= in_tdata[167:152];
      mask_r <= in_tdata[183:168];
    end
    unique case (state_r)
      ST_ZO: begin
        // zoneout splits the hidden gradient between carry and this step
        if (zo_en_r) begin
          dho_r <= qmul(one_minus(mask_r), dht_r);
          dht_r <= qmul(mask_r, dht_r);
        end else begin
          dho_r <= '0;
        end
      end
      ST_A: begin
        do_r   <= qmul(ct_r, dht_r);
        dcth_r <= qmul(go_r, dht_r);
        dtc_r  <= sat16(ONE_Q12 - 17'(qmul(ct_r, ct_r)));
      end
      ST_B: begin
        t_r     <= qmul(dtc_r, dcth_r);
        dsg_o_r <= qmul(go_r, one_minus(go_r));
        dsg_i_r <= qmul(gi_r, one_minus(gi_r));
        dsg_f_r <= qmul(gf_r, one_minus(gf_r));
        dtg_r   <= sat16(ONE_Q12 - 17'(qmul(gg_r, gg_r)));
      end
      ST_C: dct_r <= sat16(17'(dct_r) + 17'(t_r));
      ST_D: begin
        df_r <= qmul(cp_r, dct_r);
        dc_r <= qmul(gf_r, dct_r);
        di_r <= qmul(gg_r, dct_r);
        dg_r <= qmul(gi_r, dct_r);
        vo_r <= qmul(dsg_o_r, do_r);
      end
      ST_E: begin
        vg_r <= qmul(dtg_r, dg_r);
        vi_r <= qmul(dsg_i_r, di_r);
        vf_r <= qmul(dsg_f_r, df_r);
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data_r[95:0] <= {vo_r, vf_r, vg_r, vi_r, dc_r, dho_r};
          out_data_r[223:96] <= in_range_r ? {so, sf, sg, si} : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/tb_lstm_cell_backward_pointwise.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LSTM backward pointwise stage and its bias gradient store.
module tb_lstm_cell_backward_pointwise
  import lcbp_pkg::*;
();

  localparam int HIDDEN_ROWS = 256;
  localparam int ONE_Q = 4096;
  // slack after the last result before a register write or the end
  localparam int DRAIN_CYCLES = 24;

  // input element; declared MSB first so that row lands in tdata[7:0]
  typedef struct packed {
    q12_t keep_mask;
    q12_t gate_output;
    q12_t gate_forget;
    q12_t gate_cand;
    q12_t gate_input;
    q12_t grad_c_carry;
    q12_t grad_h_carry;
    q12_t grad_c_new;
    q12_t grad_h_new;
    q12_t cell_new;
    q12_t cell_prev;
    logic [7:0] row;
  } elem_t;

  // result; grad_h_out lands in tdata[15:0]
  typedef struct packed {
    acc_t bias_sum_o;
    acc_t bias_sum_f;
    acc_t bias_sum_g;
    acc_t bias_sum_i;
    q12_t grad_pre_o;
    q12_t grad_pre_f;
    q12_t grad_pre_g;
    q12_t grad_pre_i;
    q12_t grad_c_out;
    q12_t grad_h_out;
  } grads_t;

  // Golden model of the pointwise stage plus the queue of results still owed.
  class bias_grad_scoreboard;
    int bias_store[4*HIDDEN_ROWS];
    bit zoneout_on;
    grads_t owed_q[$];
    int errors;

    function int sat_q(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // floor of product >> 12, then saturate
    function int mul_q(input int a, input int b);
      int p;
      p = a * b;
      return sat_q(p >>> 12);
    endfunction

    function int tanh_lookup(input int x);
      int idx;
      if (x < -16384) idx = 0;
      else if (x > 16383) idx = 1023;
      else idx = (x + 16384) >>> 5;
      return int'(TANH_LUT[idx]);
    endfunction

    function int dtanh(input int y);
      return sat_q(ONE_Q - mul_q(y, y));
    endfunction

    function int dsig(input int y);
      return mul_q(y, sat_q(ONE_Q - y));
    endfunction

    function int bump(input int addr, input int d);
      longint s;
      s = longint'(bias_store[addr]) + d;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      bias_store[addr] = int'(s);
      return int'(s);
    endfunction

    function void note_input(input elem_t e);
      int dh, dc_tot, ct, dh_out, d_o, d_ct, df, dc, di, dg, vi, vg, vf, vo, r;
      grads_t g;
      dh = sat_q(int'(e.grad_h_new) + int'(e.grad_h_carry));
      dc_tot = sat_q(int'(e.grad_c_new) + int'(e.grad_c_carry));
      ct = tanh_lookup(e.cell_new);
      dh_out = 0;
      if (zoneout_on) begin
        dh_out = mul_q(sat_q(ONE_Q - int'(e.keep_mask)), dh);
        dh = mul_q(e.keep_mask, dh);
      end
      d_o = mul_q(ct, dh);
      d_ct = mul_q(e.gate_output, dh);
      dc_tot = sat_q(dc_tot + mul_q(dtanh(ct), d_ct));
      df = mul_q(e.cell_prev, dc_tot);
      dc = mul_q(e.gate_forget, dc_tot);
      di = mul_q(e.gate_cand, dc_tot);
      dg = mul_q(e.gate_input, dc_tot);
      vg = mul_q(dtanh(e.gate_cand), dg);
      vo = mul_q(dsig(e.gate_output), d_o);
      vi = mul_q(dsig(e.gate_input), di);
      vf = mul_q(dsig(e.gate_forget), df);
      r = int'(e.row);
      g.grad_h_out = q12_t'(dh_out);
      g.grad_c_out = q12_t'(dc);
      g.grad_pre_i = q12_t'(vi);
      g.grad_pre_g = q12_t'(vg);
      g.grad_pre_f = q12_t'(vf);
      g.grad_pre_o = q12_t'(vo);
      g.bias_sum_i = '0;
      g.bias_sum_g = '0;
      g.bias_sum_f = '0;
      g.bias_sum_o = '0;
      if (r < HIDDEN_ROWS) begin
        g.bias_sum_i = bump(r, vi);
        g.bias_sum_g = bump(r + HIDDEN_ROWS, vg);
        g.bias_sum_f = bump(r + 2*HIDDEN_ROWS, vf);
        g.bias_sum_o = bump(r + 3*HIDDEN_ROWS, vo);
      end
      owed_q.push_back(g);
    endfunction

    function void check_result(input grads_t got);
      grads_t want;
      int w[10];
      int a[10];
      string names[10];
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      names = '{"grad_h_out", "grad_c_out", "grad_pre_i", "grad_pre_g", "grad_pre_f",
                "grad_pre_o", "bias_sum_i", "bias_sum_g", "bias_sum_f", "bias_sum_o"};
      w = '{want.grad_h_out, want.grad_c_out, want.grad_pre_i, want.grad_pre_g,
            want.grad_pre_f, want.grad_pre_o, want.bias_sum_i, want.bias_sum_g,
            want.bias_sum_f, want.bias_sum_o};
      a = '{got.grad_h_out, got.grad_c_out, got.grad_pre_i, got.grad_pre_g,
            got.grad_pre_f, got.grad_pre_o, got.bias_sum_i, got.bias_sum_g,
            got.bias_sum_f, got.bias_sum_o};
      for (int k = 0; k < 10; k++) begin
        if (w[k] != a[k]) begin
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, names[k], w[k], a[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [183:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_data = '0;

  bias_grad_scoreboard sb = new();
  int tx_idle_pct = 0;   // sender gap odds per transaction, percent
  int rx_idle_pct = 0;   // receiver stall odds per cycle, percent

  lstm_cell_backward_pointwise #(.HIDDEN(HIDDEN_ROWS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result checker: a transaction completes on a rising edge with both high
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(grads_t'(out_tdata));
  end

  // Present one element; valid stays up afterwards so back-to-back elements
  // do not see a dropped valid. Gaps are inserted before the element.
  task automatic send_elem(input elem_t e);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= e;
    do @(posedge clk); while (!in_tready);
    sb.note_input(e);
  endtask

  // hold off until every owed result is back, then let the pipe drain
  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zoneout(input bit en);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= en;
    do @(posedge clk); while (!cfg_ready);
    sb.zoneout_on = en;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic q12_t rnd16();
    return q12_t'($urandom_range(0, 65535));
  endfunction

  // mostly plausible activations and gradients, some raw noise
  function automatic elem_t rand_elem();
    elem_t e;
    e = elem_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 70) begin
      e.row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : e.row;
      e.cell_prev = q12_t'($urandom_range(0, 40000) - 20000);
      e.cell_new = q12_t'($urandom_range(0, 40000) - 20000);
      e.grad_h_new = q12_t'($urandom_range(0, 16384) - 8192);
      e.grad_c_new = q12_t'($urandom_range(0, 16384) - 8192);
      e.grad_h_carry = q12_t'($urandom_range(0, 16384) - 8192);
      e.grad_c_carry = q12_t'($urandom_range(0, 16384) - 8192);
      e.gate_input = q12_t'($urandom_range(0, ONE_Q));
      e.gate_cand = q12_t'($urandom_range(0, 2*ONE_Q) - ONE_Q);
      e.gate_forget = q12_t'($urandom_range(0, ONE_Q));
      e.gate_output = q12_t'($urandom_range(0, ONE_Q));
      case ($urandom_range(0, 2))
        0: e.keep_mask = '0;
        1: e.keep_mask = q12_t'(ONE_Q);
        default: e.keep_mask = q12_t'($urandom_range(0, ONE_Q));
      endcase
    end
    return e;
  endfunction

  task automatic run_directed();
    elem_t e;
    // all fields at max, min and zero
    e = {{11{16'sh7fff}}, 8'hff};
    send_elem(e);
    e = {{11{16'sh8000}}, 8'h00};
    send_elem(e);
    e = '0;
    send_elem(e);
    // tanh table edges: below range, lowest bin, top bin, above range, both extremes
    for (int k = 0; k < 6; k++) begin
      e = rand_elem();
      e.row = 8'(k);
      case (k)
        0: e.cell_new = -16'sd16385;
        1: e.cell_new = -16'sd16384;
        2: e.cell_new = 16'sd16383;
        3: e.cell_new = 16'sd16384;
        4: e.cell_new = 16'sh8000;
        default: e.cell_new = 16'sh7fff;
      endcase
      send_elem(e);
    end
    // saturating gradient sums, keep mask at zero, one and most negative
    e = rand_elem();
    e.grad_h_new = 16'sh7fff;
    e.grad_h_carry = 16'sh7fff;
    e.grad_c_new = 16'sh8000;
    e.grad_c_carry = 16'sh8000;
    e.keep_mask = '0;
    send_elem(e);
    e.keep_mask = q12_t'(ONE_Q);
    send_elem(e);
    e.keep_mask = 16'sh8000;
    send_elem(e);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items under both zoneout settings
    write_zoneout(1'b1);
    run_directed();
    write_zoneout(1'b0);
    run_directed();

    // random: three idling regimes, each run with zoneout off, then on
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle_pct = 25; rx_idle_pct = 57; end
        1: begin tx_idle_pct = 57; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_zoneout(ph[0]);
      for (int n = 0; n < 265; n++) send_elem(rand_elem());
    end

    wait_quiet();
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (sb.owed_q.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.owed_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lcbp_pkg.sv
hdl/lstm_cell_backward_pointwise.sv
verif/tb_lstm_cell_backward_pointwise.sv
